[src/gspd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_pkg
// Shared types, constants and the group-code lookup for the symbol pair
// decoder.
// ----------------------------------------------------------------------------
package gspd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam int         SYM_W     = 5;
    localparam int         NIB_W     = 4;

    typedef struct packed {
        logic [7:0] symbol_byte;
        logic       frame_last;
    } gspd_in_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       frame_done;
        logic       frame_ok;
        logic       sync_seen;
    } gspd_out_t;

    typedef struct packed {
        logic consume;
        logic frame_last;
        logic half_pair;
        logic frame_failed;
    } gspd_status_t;

    // Bit 4 set: not one of the 16 valid codes.
    function automatic logic [SYM_W-1:0] gspd_sym_to_nibble(input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] nib;
        case (sym)
            5'h09:   nib = 5'h08;
            5'h0A:   nib = 5'h00;
            5'h0B:   nib = 5'h01;
            5'h0D:   nib = 5'h0C;
            5'h0E:   nib = 5'h04;
            5'h0F:   nib = 5'h05;
            5'h12:   nib = 5'h02;
            5'h13:   nib = 5'h03;
            5'h15:   nib = 5'h0F;
            5'h16:   nib = 5'h06;
            5'h17:   nib = 5'h07;
            5'h19:   nib = 5'h09;
            5'h1A:   nib = 5'h0A;
            5'h1B:   nib = 5'h0B;
            5'h1D:   nib = 5'h0D;
            5'h1E:   nib = 5'h0E;
            default: nib = 5'h10;
        endcase
        return nib;
    endfunction

endpackage

[src/gspd_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_in_stage
// Input register: captures one symbol beat and holds it until the decode
// core consumes it.
// ----------------------------------------------------------------------------
module gspd_in_stage
    import gspd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gspd_in_t s_payload,
    input  logic     consume,
    output logic     beat_valid,
    output gspd_in_t beat
);

    logic     valid_reg;
    gspd_in_t beat_reg;

    assign s_ready    = !valid_reg || consume;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (consume) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_payload;
        end
    end

endmodule

[src/gspd_decode_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_decode_core
// Pair decoder: table lookup, pair assembly and frame status flags.
// ----------------------------------------------------------------------------
module gspd_decode_core
    import gspd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         beat_valid,
    input  gspd_in_t     beat,
    input  logic         res_ready,
    output logic         res_valid,
    output gspd_out_t    res,
    output gspd_status_t status
);

    logic [NIB_W-1:0] high_nibble_reg, high_nibble_next;
    logic             half_pair_reg, half_pair_next;
    logic             sync_flag_reg, sync_flag_next;
    logic             frame_failed_reg, frame_failed_next;

    logic [SYM_W-1:0] nib;
    logic             is_sync;
    logic             emit;
    logic [7:0]       data;
    logic             need_res;
    logic             consume;

    always_comb begin
        nib               = gspd_sym_to_nibble(beat.symbol_byte[SYM_W-1:0]);
        is_sync           = (beat.symbol_byte == SYNC_BYTE);
        high_nibble_next  = high_nibble_reg;
        half_pair_next    = half_pair_reg;
        sync_flag_next    = sync_flag_reg;
        frame_failed_next = frame_failed_reg;
        emit              = 1'b0;
        data              = 8'h00;

        if (!frame_failed_reg) begin
            if (!half_pair_reg) begin
                if (is_sync) begin
                    sync_flag_next = 1'b1;
                end else if (beat.frame_last || nib[NIB_W]) begin
                    frame_failed_next = 1'b1;
                end else begin
                    high_nibble_next = nib[NIB_W-1:0];
                    half_pair_next   = 1'b1;
                end
            end else begin
                half_pair_next = 1'b0;
                if (is_sync || nib[NIB_W]) begin
                    frame_failed_next = 1'b1;
                end else begin
                    data = {high_nibble_reg, nib[NIB_W-1:0]};
                    emit = 1'b1;
                end
            end
        end

        need_res = emit || beat.frame_last;
        consume  = beat_valid && (!need_res || res_ready);

        res_valid      = beat_valid && need_res;
        res.byte_valid = emit;
        res.data_byte  = data;
        res.frame_done = beat.frame_last;
        res.frame_ok   = beat.frame_last && !frame_failed_next;
        res.sync_seen  = beat.frame_last && sync_flag_next;

        status.consume      = consume;
        status.frame_last   = beat.frame_last;
        status.half_pair    = half_pair_reg;
        status.frame_failed = frame_failed_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_nibble_reg  <= '0;
            half_pair_reg    <= 1'b0;
            sync_flag_reg    <= 1'b0;
            frame_failed_reg <= 1'b0;
        end else if (consume) begin
            if (beat.frame_last) begin
                high_nibble_reg  <= '0;
                half_pair_reg    <= 1'b0;
                sync_flag_reg    <= 1'b0;
                frame_failed_reg <= 1'b0;
            end else begin
                high_nibble_reg  <= high_nibble_next;
                half_pair_reg    <= half_pair_next;
                sync_flag_reg    <= sync_flag_next;
                frame_failed_reg <= frame_failed_next;
            end
        end
    end

endmodule

[src/gspd_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module gspd_out_stage
    import gspd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      res_valid,
    output logic      res_ready,
    input  gspd_out_t res,
    output logic      m_valid,
    input  logic      m_ready,
    output gspd_out_t m_payload
);

    logic      valid_reg;
    gspd_out_t payload_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            payload_reg <= res;
        end
    end

endmodule

[src/gcr_symbol_pair_decoder.sv]
`timescale 1ns / 1ps
// Takes one 5-bit group-code symbol beat per cycle while m_ready is high and
// gives one decoded data byte per symbol pair, plus a status beat at frame
// end. Beats pass the input register, the single decode stage of lookup and
// flag update, then the result register. The sink must void every byte
// emitted by a frame ending with frame_ok low; the block does not enforce it.
// ----------------------------------------------------------------------------
// gcr_symbol_pair_decoder
// Group-code symbol pair decoder with sync detection and frame status.
// ----------------------------------------------------------------------------
module gcr_symbol_pair_decoder
    import gspd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gspd_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output gspd_out_t m_payload
);

    logic         beat_valid;
    gspd_in_t     beat;
    logic         res_valid;
    logic         res_ready;
    gspd_out_t    res;
    gspd_status_t status;

    gspd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .consume    (status.consume),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    gspd_decode_core u_decode_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    gspd_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.frame_done |-> !m_payload.frame_ok && !m_payload.sync_seen)
        else $error("frame status on a beat that does not end a frame");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.byte_valid |-> m_payload.data_byte == 8'h00)
        else $error("data byte not zero without a decoded byte");

    a_frame_state_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.consume && status.frame_last |=> !status.half_pair && !status.frame_failed)
        else $error("frame state not cleared after frame end");

    a_result_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        status.consume && res_valid |-> res_ready)
        else $error("beat consumed with no room for its result");

endmodule

[bench/gcr_symbol_pair_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_symbol_pair_decoder_tb
// The bench drives symbol frames into the pair decoder through a bursty
// sender and a stalling receiver. Every output beat is compared field by field
// with the known rows' own values or a local decode of the same frames. A
// short table covers sync marks, the lowest and highest data codes, unused
// high bits and each way a frame can fail. After it come random frames,
// mostly well formed, some corrupted and some pure noise.
// ----------------------------------------------------------------------------
module gcr_symbol_pair_decoder_tb;
    import gspd_pkg::*;

    // Group codes indexed by nibble, nibble 0 in the low five bits.
    localparam logic [16*5-1:0] GCR_CODES = {
        5'h15, 5'h1E, 5'h1D, 5'h0D, 5'h1B, 5'h1A, 5'h19, 5'h09,
        5'h17, 5'h16, 5'h0F, 5'h0E, 5'h13, 5'h12, 5'h0B, 5'h0A
    };
    localparam int    DIRECTED_ROWS = 24;
    localparam int    TOTAL_BEATS   = 750;
    localparam int    MAX_PRINTS    = 60;

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       known;
        gspd_out_t  want;
    } stim_row_t;

    // want = {byte_valid, data_byte, frame_done, frame_ok, sync_seen}
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        {8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h0A, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h0A, 1'b0, 1'b1, 1'b1, 8'h00, 3'b000},
        {8'h15, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h15, 1'b0, 1'b1, 1'b1, 8'hFF, 3'b000},
        {8'hE9, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h3D, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h12, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h13, 1'b1, 1'b1, 1'b1, 8'h23, 3'b111},
        {8'h0A, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h0B, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h16, 1'b1, 1'b1, 1'b0, 8'h00, 3'b100},
        {8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h0A, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h0A, 1'b1, 1'b1, 1'b0, 8'h00, 3'b100},
        {8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h0A, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h1F, 1'b1, 1'b1, 1'b0, 8'h00, 3'b101},
        {8'h0A, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'h1C, 1'b0, 1'b0, 1'b0, 8'h00, 3'b000},
        {8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 3'b100},
        {8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 3'b111},
        {8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 3'b100}
    };

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    gspd_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    gspd_out_t m_payload;

    gspd_out_t   pending_results [$];
    gspd_out_t   oldest_result;
    int unsigned mismatches  = 0;
    int unsigned beats_sent  = 0;
    int unsigned burst_left  = 4;
    logic [31:0] sink_cycle  = '0;
    int unsigned sink_hold   = 0;

    // Local decoder state
    logic [3:0] pend_nib   = '0;
    logic       pend_valid = 1'b0;
    logic       sync_hit   = 1'b0;
    logic       frame_bad  = 1'b0;

    gcr_symbol_pair_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    function automatic bit lookup_nibble(input logic [4:0] code, output logic [3:0] nib);
        nib = '0;
        for (int n = 0; n < 16; n++) begin
            if (GCR_CODES[n*5 +: 5] == code) begin
                nib = 4'(n);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit decode_symbol(input gspd_in_t beat, output gspd_out_t res);
        logic [3:0] nib;
        bit         code_ok;
        bit         emit;
        logic [7:0] data;
        emit    = 1'b0;
        data    = '0;
        code_ok = lookup_nibble(beat.symbol_byte[4:0], nib);
        if (!frame_bad) begin
            if (!pend_valid) begin
                if (beat.symbol_byte == SYNC_BYTE) begin
                    sync_hit = 1'b1;
                end else if (beat.frame_last || !code_ok) begin
                    frame_bad = 1'b1;
                end else begin
                    pend_nib   = nib;
                    pend_valid = 1'b1;
                end
            end else begin
                pend_valid = 1'b0;
                if (beat.symbol_byte == SYNC_BYTE || !code_ok) begin
                    frame_bad = 1'b1;
                end else begin
                    data = {pend_nib, nib};
                    emit = 1'b1;
                end
            end
        end
        res.byte_valid = emit;
        res.data_byte  = data;
        res.frame_done = beat.frame_last;
        res.frame_ok   = beat.frame_last && !frame_bad;
        res.sync_seen  = beat.frame_last && sync_hit;
        if (beat.frame_last) begin
            pend_nib   = '0;
            pend_valid = 1'b0;
            sync_hit   = 1'b0;
            frame_bad  = 1'b0;
        end
        return emit || beat.frame_last;
    endfunction

    function automatic logic [7:0] coded_symbol();
        logic [3:0] nib;
        logic [2:0] top;
        nib = 4'($urandom_range(0, 15));
        top = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
        return {top, GCR_CODES[nib*5 +: 5]};
    endfunction

    function automatic gspd_in_t make_beat(input logic [7:0] sym);
        gspd_in_t beat;
        beat.symbol_byte = sym;
        beat.frame_last  = 1'b0;
        return beat;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic send_beat(input logic [7:0] sym, input logic last,
                             input logic known, input gspd_out_t want);
        gspd_in_t  beat;
        gspd_out_t predicted;
        bit        has_result;
        beat.symbol_byte = sym;
        beat.frame_last  = last;
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        has_result = decode_symbol(beat, predicted);
        if (known)
            pending_results.insert(pending_results.size(), want);
        else if (has_result)
            pending_results.insert(pending_results.size(), predicted);
        beats_sent++;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_random_frame();
        gspd_in_t    frame_q [$];
        gspd_in_t    beat;
        int unsigned kind;
        int unsigned pairs;
        int unsigned spot;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 8)) begin
                beat = make_beat(($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                              : 8'($urandom_range(0, 255)));
                frame_q.insert(frame_q.size(), beat);
            end
        end else begin
            repeat ($urandom_range(0, 2)) frame_q.insert(frame_q.size(), make_beat(SYNC_BYTE));
            pairs = $urandom_range(0, 6);
            repeat (pairs) begin
                if ($urandom_range(0, 7) == 0)
                    frame_q.insert(frame_q.size(), make_beat(SYNC_BYTE));
                frame_q.insert(frame_q.size(), make_beat(coded_symbol()));
                frame_q.insert(frame_q.size(), make_beat(coded_symbol()));
            end
            if (pairs == 0 || $urandom_range(0, 3) == 0)
                frame_q.insert(frame_q.size(), make_beat(SYNC_BYTE));
            if (kind == 8) begin
                frame_q.insert(frame_q.size(), make_beat(coded_symbol()));
            end else if (kind == 7) begin
                spot = $urandom_range(0, frame_q.size() - 1);
                frame_q[spot].symbol_byte = $urandom_range(0, 1) ? SYNC_BYTE
                                                                  : 8'($urandom_range(0, 255));
            end
        end
        frame_q[frame_q.size() - 1].frame_last = 1'b1;
        foreach (frame_q[i])
            send_beat(frame_q[i].symbol_byte, frame_q[i].frame_last, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 1;
        if (sink_hold != 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            case (sink_cycle[8:7])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= 1'($urandom_range(0, 1));
                2'd2: m_ready <= (sink_cycle[1:0] == 2'b11);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        m_ready   <= 1'b0;
                        sink_hold <= $urandom_range(1, 20);
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", m_payload));
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("byte_valid", 8'(m_payload.byte_valid),
                            8'(oldest_result.byte_valid));
                check_field("data_byte",  m_payload.data_byte,  oldest_result.data_byte);
                check_field("frame_done", 8'(m_payload.frame_done),
                            8'(oldest_result.frame_done));
                check_field("frame_ok",   8'(m_payload.frame_ok),
                            8'(oldest_result.frame_ok));
                check_field("sync_seen",  8'(m_payload.sync_seen),
                            8'(oldest_result.sync_seen));
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].sym, directed_rows[i].last,
                      directed_rows[i].known, directed_rows[i].want);
        while (beats_sent < TOTAL_BEATS)
            send_random_frame();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
src/gspd_pkg.sv
src/gspd_in_stage.sv
src/gspd_decode_core.sv
src/gspd_out_stage.sv
src/gcr_symbol_pair_decoder.sv
bench/gcr_symbol_pair_decoder_tb.sv
